// ===== hdl/assert_macros.svh =====
// Shared assertion macros for the frame parser checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/upvt_pkg.sv =====
package upvt_pkg;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_SYNC     = 3'd2,
        ST_CHECKSUM = 3'd3,
        ST_IGNORED  = 3'd4,
        ST_LENGTH   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_STATUS,
        EM_FIELDS
    } em_state_t;

    typedef struct packed {
        logic [6:0] offset;   // byte offset within the payload
        logic [1:0] size_m1;  // field size in bytes, minus one
        logic       sgn;      // two's complement field
    } pvt_field_t;

    localparam logic [7:0]  SYNC_1          = 8'hB5;
    localparam logic [7:0]  SYNC_2          = 8'h62;
    localparam logic [7:0]  CLASS_NAV       = 8'h01;
    localparam logic [7:0]  ID_PVT          = 8'h07;
    localparam logic [15:0] PVT_PAYLOAD_LEN = 16'd92;
    localparam logic [7:0]  PVT_LAST_IDX    = 8'd99;
    localparam logic [7:0]  MIN_LAST_IDX    = 8'd7;
    localparam logic [7:0]  CKSUM_LEAD_IDX  = 8'd4;
    localparam logic [7:0]  PAYLOAD_START   = 8'd6;
    localparam int          HDR_BYTES       = 6;
    localparam int          FIELD_COUNT     = 31;
    localparam logic [4:0]  FIELD_LAST      = 5'(FIELD_COUNT - 1);

    function automatic pvt_field_t pvt_field(input logic [4:0] idx);
        pvt_field_t f;
        f = '{offset: 7'd0, size_m1: 2'd0, sgn: 1'b0};
        unique case (idx)
            5'd0:    f = '{offset: 7'd0,  size_m1: 2'd3, sgn: 1'b0};
            5'd1:    f = '{offset: 7'd4,  size_m1: 2'd1, sgn: 1'b0};
            5'd2:    f = '{offset: 7'd6,  size_m1: 2'd0, sgn: 1'b0};
            5'd3:    f = '{offset: 7'd7,  size_m1: 2'd0, sgn: 1'b0};
            5'd4:    f = '{offset: 7'd8,  size_m1: 2'd0, sgn: 1'b0};
            5'd5:    f = '{offset: 7'd9,  size_m1: 2'd0, sgn: 1'b0};
            5'd6:    f = '{offset: 7'd10, size_m1: 2'd0, sgn: 1'b0};
            5'd7:    f = '{offset: 7'd11, size_m1: 2'd0, sgn: 1'b0};
            5'd8:    f = '{offset: 7'd12, size_m1: 2'd3, sgn: 1'b0};
            5'd9:    f = '{offset: 7'd16, size_m1: 2'd3, sgn: 1'b1};
            5'd10:   f = '{offset: 7'd20, size_m1: 2'd0, sgn: 1'b0};
            5'd11:   f = '{offset: 7'd21, size_m1: 2'd0, sgn: 1'b0};
            5'd12:   f = '{offset: 7'd22, size_m1: 2'd0, sgn: 1'b0};
            5'd13:   f = '{offset: 7'd23, size_m1: 2'd0, sgn: 1'b0};
            5'd14:   f = '{offset: 7'd24, size_m1: 2'd3, sgn: 1'b1};
            5'd15:   f = '{offset: 7'd28, size_m1: 2'd3, sgn: 1'b1};
            5'd16:   f = '{offset: 7'd32, size_m1: 2'd3, sgn: 1'b1};
            5'd17:   f = '{offset: 7'd36, size_m1: 2'd3, sgn: 1'b1};
            5'd18:   f = '{offset: 7'd40, size_m1: 2'd3, sgn: 1'b0};
            5'd19:   f = '{offset: 7'd44, size_m1: 2'd3, sgn: 1'b0};
            5'd20:   f = '{offset: 7'd48, size_m1: 2'd3, sgn: 1'b1};
            5'd21:   f = '{offset: 7'd52, size_m1: 2'd3, sgn: 1'b1};
            5'd22:   f = '{offset: 7'd56, size_m1: 2'd3, sgn: 1'b1};
            5'd23:   f = '{offset: 7'd60, size_m1: 2'd3, sgn: 1'b1};
            5'd24:   f = '{offset: 7'd64, size_m1: 2'd3, sgn: 1'b1};
            5'd25:   f = '{offset: 7'd68, size_m1: 2'd3, sgn: 1'b0};
            5'd26:   f = '{offset: 7'd72, size_m1: 2'd3, sgn: 1'b0};
            5'd27:   f = '{offset: 7'd76, size_m1: 2'd1, sgn: 1'b0};
            5'd28:   f = '{offset: 7'd84, size_m1: 2'd3, sgn: 1'b1};
            5'd29:   f = '{offset: 7'd88, size_m1: 2'd1, sgn: 1'b1};
            5'd30:   f = '{offset: 7'd90, size_m1: 2'd1, sgn: 1'b0};
            default: f = '{offset: 7'd0,  size_m1: 2'd0, sgn: 1'b0};
        endcase
        return f;
    endfunction

endpackage

// ===== hdl/upvt_ram.sv =====
module upvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/ubx_nav_pvt_frame_parser_top.sv =====
// Channel  Dir  tdata (low bit up)                      tuser         tlast
// s_*      in   data_byte[7:0]                          -             frame_end
// m_*      out  status[2:0] field_id[7:3] value[39:8]   field_signed  last_result
//
// Bytes are taken one per cycle. A frame's final byte is held off while the
// previous frame's results are still being read out of the frame store.
// A valid frame yields 31 results from 86 store bytes, read one per cycle
// through the single RAM read port (reserved payload bytes are skipped); a
// rejected frame yields one result. The store is split into two banks so the
// next frame fills one bank while the other is read.
// No clearing pass after reset; rst_n clears control only.
// A stalled output holds its result; reads pause until it is taken.
module ubx_nav_pvt_frame_parser_top
    import upvt_pkg::*;
#(
    parameter int STORE_DEPTH = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[2:0], field_id[7:3], field_value[39:8]
    output logic        m_tuser,   // field_signed
    output logic        m_tlast
);

    localparam int IW = $clog2(STORE_DEPTH);
    localparam int AW = IW + 1;

    // input side
    logic [7:0]  byte_count_reg, byte_count_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [15:0] held_reg, held_next;
    logic        wr_bank_reg, wr_bank_next;
    logic [7:0]  hdr_reg [HDR_BYTES];

    // emitter
    em_state_t   em_state_reg, em_state_next;
    logic [4:0]  fld_reg, fld_next;
    logic [1:0]  k_reg, k_next;
    logic        rd_bank_reg, rd_bank_next;
    status_t     job_status_reg, job_status_next;
    logic        cap_valid_reg, cap_valid_next;
    logic        cap_last_reg, cap_last_next;
    logic [1:0]  cap_k_reg, cap_k_next;
    logic [4:0]  cap_fld_reg, cap_fld_next;
    logic [31:0] acc_reg, acc_next;
    logic        hold_reg, hold_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    status_t     m_status_reg, m_status_next;
    logic [4:0]  m_id_reg, m_id_next;
    logic [31:0] m_value_reg, m_value_next;
    logic        m_signed_reg, m_signed_next;
    logic        m_last_reg, m_last_next;

    logic        in_accept;
    logic        end_accept;
    logic        busy;
    logic        out_free;
    logic        store_we;
    logic [AW-1:0] store_waddr;
    logic [AW-1:0] store_raddr;
    logic [7:0]  store_rdata;
    logic        issue_go;
    logic        k_last;
    logic        cap_done;
    logic [31:0] cap_val;
    logic [7:0]  sum_a_upd;
    logic [7:0]  sum_b_upd;
    status_t     frame_status;
    pvt_field_t  cur_field;
    pvt_field_t  cap_field;

    assign busy       = (em_state_reg != EM_IDLE) || cap_valid_reg || hold_reg;
    assign s_tready   = !s_tlast || !busy;
    assign in_accept  = s_tvalid && s_tready;
    assign end_accept = in_accept && s_tlast;
    assign out_free   = !m_valid_reg || m_tready;

    // ---------------- frame store ----------------
    assign store_we    = in_accept && ({1'b0, byte_count_reg} < 9'(STORE_DEPTH));
    assign store_waddr = {wr_bank_reg, byte_count_reg[IW-1:0]};

    upvt_ram #(
        .WIDTH (8),
        .DEPTH (2 ** AW)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (s_tdata),
        .re    (issue_go),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    // ---------------- checksum and frame checks ----------------
    always_comb
    begin
        sum_a_upd = sum_a_reg;
        sum_b_upd = sum_b_reg;
        // the byte two positions back leaves the delay line into the sums
        if (byte_count_reg >= CKSUM_LEAD_IDX)
        begin
            sum_a_upd = sum_a_reg + held_reg[15:8];
            sum_b_upd = sum_b_reg + sum_a_upd;
        end
    end

    always_comb
    begin
        priority if (byte_count_reg < MIN_LAST_IDX)
            frame_status = ST_SHORT;
        else if (hdr_reg[0] != SYNC_1 || hdr_reg[1] != SYNC_2)
            frame_status = ST_SYNC;
        else if (held_reg[7:0] != sum_a_upd || s_tdata != sum_b_upd)
            frame_status = ST_CHECKSUM;
        else if (hdr_reg[2] != CLASS_NAV || hdr_reg[3] != ID_PVT)
            frame_status = ST_IGNORED;
        else if ({hdr_reg[5], hdr_reg[4]} != PVT_PAYLOAD_LEN
                 || byte_count_reg != PVT_LAST_IDX)
            frame_status = ST_LENGTH;
        else
            frame_status = ST_OK;
    end

    always_comb
    begin
        byte_count_next = byte_count_reg;
        sum_a_next      = sum_a_reg;
        sum_b_next      = sum_b_reg;
        held_next       = held_reg;
        wr_bank_next    = wr_bank_reg;
        if (in_accept)
        begin
            if (s_tlast)
            begin
                byte_count_next = 8'd0;
                sum_a_next      = 8'd0;
                sum_b_next      = 8'd0;
                held_next       = 16'd0;
                wr_bank_next    = ~wr_bank_reg;
            end
            else
            begin
                sum_a_next = sum_a_upd;
                sum_b_next = sum_b_upd;
                held_next  = {held_reg[7:0], s_tdata};
                if (byte_count_reg != 8'hFF)
                begin
                    byte_count_next = byte_count_reg + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < HDR_BYTES; i++)
        begin
            if (in_accept && byte_count_reg == 8'(i))
            begin
                hdr_reg[i] <= s_tdata;
            end
        end
    end

    // ---------------- emitter ----------------
    assign cur_field = pvt_field(fld_reg);
    assign cap_field = pvt_field(cap_fld_reg);
    assign k_last    = (k_reg == cur_field.size_m1);
    assign cap_done  = cap_valid_reg && cap_last_reg;

    // a field's first read waits until its finished predecessor can move out
    assign issue_go = (em_state_reg == EM_FIELDS)
                      && ((k_reg != 2'd0) || !((cap_done || hold_reg) && !out_free));

    assign store_raddr = {rd_bank_reg,
                          IW'({1'b0, cur_field.offset} + PAYLOAD_START) + IW'(k_reg)};

    assign cap_val = ((cap_k_reg == 2'd0) ? 32'd0 : acc_reg)
                     | ({24'd0, store_rdata} << {cap_k_reg, 3'b000});

    always_comb
    begin
        em_state_next = em_state_reg;
        unique case (em_state_reg)
            EM_IDLE:
            begin
                if (end_accept)
                begin
                    em_state_next = (frame_status == ST_OK) ? EM_FIELDS : EM_STATUS;
                end
            end
            EM_STATUS:
            begin
                if (out_free)
                begin
                    em_state_next = EM_IDLE;
                end
            end
            EM_FIELDS:
            begin
                if (issue_go && k_last && fld_reg == FIELD_LAST)
                begin
                    em_state_next = EM_IDLE;
                end
            end
            default:
            begin
                em_state_next = EM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        fld_next        = fld_reg;
        k_next          = k_reg;
        rd_bank_next    = rd_bank_reg;
        job_status_next = job_status_reg;
        cap_valid_next  = issue_go;
        cap_last_next   = cap_last_reg;
        cap_k_next      = cap_k_reg;
        cap_fld_next    = cap_fld_reg;
        acc_next        = acc_reg;
        hold_next       = hold_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_id_next       = m_id_reg;
        m_value_next    = m_value_reg;
        m_signed_next   = m_signed_reg;
        m_last_next     = m_last_reg;

        if (end_accept)
        begin
            fld_next        = 5'd0;
            k_next          = 2'd0;
            rd_bank_next    = wr_bank_reg;
            job_status_next = frame_status;
        end

        if (issue_go)
        begin
            cap_last_next = k_last;
            cap_k_next    = k_reg;
            cap_fld_next  = fld_reg;
            if (k_last)
            begin
                k_next   = 2'd0;
                fld_next = fld_reg + 5'd1;
            end
            else
            begin
                k_next = k_reg + 2'd1;
            end
        end

        if (cap_valid_reg)
        begin
            if (!cap_last_reg || !out_free)
            begin
                acc_next = cap_val;
            end
            if (cap_last_reg && !out_free)
            begin
                hold_next = 1'b1;
            end
        end

        unique case (em_state_reg)
            EM_STATUS:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = job_status_reg;
                    m_id_next     = 5'd0;
                    m_value_next  = 32'd0;
                    m_signed_next = 1'b0;
                    m_last_next   = 1'b1;
                end
            end
            EM_IDLE, EM_FIELDS:
            begin
                if (out_free && (cap_done || hold_reg))
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = ST_OK;
                    m_id_next     = cap_fld_reg;
                    m_value_next  = hold_reg ? acc_reg : cap_val;
                    m_signed_next = cap_field.sgn;
                    m_last_next   = (cap_fld_reg == FIELD_LAST);
                    hold_next     = 1'b0;
                end
            end
            default:
            begin
                m_valid_next = m_valid_reg && !m_tready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= 8'd0;
            sum_a_reg      <= 8'd0;
            sum_b_reg      <= 8'd0;
            held_reg       <= 16'd0;
            wr_bank_reg    <= 1'b0;
            em_state_reg   <= EM_IDLE;
            cap_valid_reg  <= 1'b0;
            hold_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            sum_a_reg      <= sum_a_next;
            sum_b_reg      <= sum_b_next;
            held_reg       <= held_next;
            wr_bank_reg    <= wr_bank_next;
            em_state_reg   <= em_state_next;
            cap_valid_reg  <= cap_valid_next;
            hold_reg       <= hold_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fld_reg        <= fld_next;
        k_reg          <= k_next;
        rd_bank_reg    <= rd_bank_next;
        job_status_reg <= job_status_next;
        cap_last_reg   <= cap_last_next;
        cap_k_reg      <= cap_k_next;
        cap_fld_reg    <= cap_fld_next;
        acc_reg        <= acc_next;
        m_status_reg   <= m_status_next;
        m_id_reg       <= m_id_next;
        m_value_reg    <= m_value_next;
        m_signed_reg   <= m_signed_next;
        m_last_reg     <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_value_reg, m_id_reg, m_status_reg};
    assign m_tuser  = m_signed_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== hdl/upvt_checker.sv =====
`include "assert_macros.svh"

module upvt_checker
    import upvt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    logic [41:0] out_word;
    logic        in_mid;
    logic        err_seen;
    logic        err_bare;
    logic        ok_seen;
    logic        ok_last;
    logic        codes_ok;

    assign out_word = {m_tlast, m_tuser, m_tdata};
    assign in_mid   = s_tvalid && !s_tlast;
    assign err_seen = m_tvalid && (m_tdata[2:0] != ST_OK);
    assign err_bare = m_tlast && !m_tuser && (m_tdata[39:3] == 37'd0);
    assign ok_seen  = m_tvalid && (m_tdata[2:0] == ST_OK);
    assign ok_last  = (m_tlast == (m_tdata[7:3] == FIELD_LAST));
    assign codes_ok = (m_tdata[2:0] <= ST_LENGTH) && (m_tdata[7:3] <= FIELD_LAST);

    // hold a stalled result
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(out_word))

    // bytes inside a frame are never held off
    `ASSERT_IMPLIES(a_in_open, clk, rst_n, in_mid, s_tready)

    // a rejected frame gives one bare, final result
    `ASSERT_IMPLIES(a_err_bare, clk, rst_n, err_seen, err_bare)

    // a valid frame ends exactly on its last field
    `ASSERT_IMPLIES(a_ok_last, clk, rst_n, ok_seen, ok_last)

    // status and field index stay in range
    `ASSERT_IMPLIES(a_codes, clk, rst_n, m_tvalid, codes_ok)

endmodule

bind ubx_nav_pvt_frame_parser_top upvt_checker u_upvt_checker (.*);
